### src/fps_pkg.sv
// Shared types, phase codes and thresholds for the flight phase sequencer.
package fps_pkg;

  // Field widths
  localparam int unsigned RawW   = 20;
  localparam int unsigned VelW   = 16;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned AltW   = 19;
  localparam int unsigned PhaseW = 4;
  localparam int unsigned LatchW = 2;
  localparam int unsigned CalW   = 10;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 18;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_CALIB_SAMPLES = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_PULSE_MS      = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_MOTOR_OFF_MS  = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_SHUTDOWN_MS   = 2'd3;

  // Register reset values
  localparam logic [9:0]  CALIB_SAMPLES_RST = 10'd1000;
  localparam logic [15:0] PULSE_MS_RST      = 16'd2000;
  localparam logic [15:0] MOTOR_OFF_MS_RST  = 16'd3000;
  localparam logic [17:0] SHUTDOWN_MS_RST   = 18'd60000;

  // Flight phases
  localparam logic [PhaseW-1:0] PH_PAD      = 4'd0;
  localparam logic [PhaseW-1:0] PH_ASCEND   = 4'd1;
  localparam logic [PhaseW-1:0] PH_APOGEE   = 4'd2;
  localparam logic [PhaseW-1:0] PH_DESC1    = 4'd3;
  localparam logic [PhaseW-1:0] PH_SEPARATE = 4'd4;
  localparam logic [PhaseW-1:0] PH_DESC2    = 4'd5;
  localparam logic [PhaseW-1:0] PH_ALT_FIX  = 4'd6;
  localparam logic [PhaseW-1:0] PH_DESC3    = 4'd7;
  localparam logic [PhaseW-1:0] PH_LANDING  = 4'd8;

  // Latch levels
  localparam logic [LatchW-1:0] LATCH_NONE = 2'd0;
  localparam logic [LatchW-1:0] LATCH_DESC = 2'd1;
  localparam logic [LatchW-1:0] LATCH_SEP  = 2'd2;

  // Altitude thresholds, cm
  localparam logic [AltW-1:0] ALT_500   = 19'd500;
  localparam logic [AltW-1:0] ALT_4000  = 19'd4000;
  localparam logic [AltW-1:0] ALT_5000  = 19'd5000;
  localparam logic [AltW-1:0] ALT_6000  = 19'd6000;
  localparam logic [AltW-1:0] ALT_18000 = 19'd18000;
  localparam logic [AltW-1:0] ALT_22500 = 19'd22500;
  localparam logic [AltW-1:0] ALT_39500 = 19'd39500;
  localparam logic [AltW-1:0] ALT_MAX   = 19'h7FFFF;

  // Velocity thresholds, cm/s
  localparam logic signed [VelW-1:0] VEL_ZERO  = 16'sd0;
  localparam logic signed [VelW-1:0] VEL_P100  = 16'sd100;
  localparam logic signed [VelW-1:0] VEL_M100  = -16'sd100;
  localparam logic signed [VelW-1:0] VEL_M200  = -16'sd200;
  localparam logic signed [VelW-1:0] VEL_P300  = 16'sd300;
  localparam logic signed [VelW-1:0] VEL_M300  = -16'sd300;

  typedef struct packed {
    logic [9:0]  calib_samples;
    logic [15:0] pulse_ms;
    logic [15:0] motor_off_ms;
    logic [17:0] shutdown_ms;
  } cfg_t;

  typedef struct packed {
    logic [PhaseW-1:0] flight_phase;
    logic [AltW-1:0]   relative_altitude;
    logic              separation_drive;
    logic              buzzer_on;
    logic              motors_off;
    logic              system_off;
  } result_t;

endpackage

### src/fps_ladder.sv
// Prioritized threshold ladder: next flight phase and latch level.
module fps_ladder (
  input  logic [fps_pkg::AltW-1:0]          alt_i,
  input  logic signed [fps_pkg::VelW-1:0]   vel_i,
  input  logic [fps_pkg::PhaseW-1:0]        phase_i,
  input  logic [fps_pkg::LatchW-1:0]        latch_i,
  output logic [fps_pkg::PhaseW-1:0]        phase_o,
  output logic [fps_pkg::LatchW-1:0]        latch_o
);

  logic l0, l2, llt2, llt3;

  assign l0   = (latch_i == fps_pkg::LATCH_NONE);
  assign l2   = (latch_i == fps_pkg::LATCH_SEP);
  assign llt2 = (latch_i == fps_pkg::LATCH_NONE) || (latch_i == fps_pkg::LATCH_DESC);
  assign llt3 = llt2 || l2;

  // first match wins; no match holds the phase
  always_comb begin
    phase_o = phase_i;
    latch_o = latch_i;
    if (alt_i < fps_pkg::ALT_500 && vel_i >= fps_pkg::VEL_ZERO &&
        vel_i < fps_pkg::VEL_P100 && l0) begin
      phase_o = fps_pkg::PH_PAD;
    end else if (alt_i >= fps_pkg::ALT_500 && vel_i >= fps_pkg::VEL_P100 && l0) begin
      phase_o = fps_pkg::PH_ASCEND;
    end else if (alt_i > fps_pkg::ALT_6000 && vel_i < fps_pkg::VEL_P100 &&
                 vel_i > fps_pkg::VEL_M100 && l0) begin
      phase_o = fps_pkg::PH_APOGEE;
    end else if (alt_i > fps_pkg::ALT_5000 && vel_i <= fps_pkg::VEL_M200 && llt2) begin
      phase_o = fps_pkg::PH_DESC1;
      latch_o = fps_pkg::LATCH_DESC;
    end else if (alt_i < fps_pkg::ALT_5000 && alt_i > fps_pkg::ALT_4000 &&
                 vel_i < fps_pkg::VEL_M200 && llt3) begin
      phase_o = fps_pkg::PH_SEPARATE;
      latch_o = fps_pkg::LATCH_SEP;
    end else if (alt_i < fps_pkg::ALT_39500 && alt_i > fps_pkg::ALT_22500 &&
                 vel_i < fps_pkg::VEL_M200) begin
      phase_o = fps_pkg::PH_DESC2;
      latch_o = fps_pkg::LATCH_SEP;
    end else if (alt_i < fps_pkg::ALT_22500 && alt_i > fps_pkg::ALT_18000 &&
                 vel_i > fps_pkg::VEL_M300 && vel_i < fps_pkg::VEL_P300 && l2) begin
      phase_o = fps_pkg::PH_ALT_FIX;
    end else if (alt_i < fps_pkg::ALT_18000 && vel_i < fps_pkg::VEL_M200 && l2) begin
      phase_o = fps_pkg::PH_DESC3;
    end else if (alt_i < fps_pkg::ALT_500 && vel_i < fps_pkg::VEL_P100 &&
                 vel_i > fps_pkg::VEL_M100 && l2) begin
      phase_o = fps_pkg::PH_LANDING;
    end
  end

endmodule

### src/fps_state.sv
// Sequencer state: calibration, phase, separation pulse and landing timers.
module fps_state (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              step_i,
  input  logic signed [fps_pkg::RawW-1:0]   raw_altitude_i,
  input  logic signed [fps_pkg::VelW-1:0]   vertical_velocity_i,
  input  logic [fps_pkg::TimeW-1:0]         now_ms_i,
  input  logic                              separate_cmd_i,
  input  fps_pkg::cfg_t                     cfg_i,
  output fps_pkg::result_t                  result_o
);

  logic [fps_pkg::PhaseW-1:0] phase_q, phase_d, ladder_phase;
  logic [fps_pkg::LatchW-1:0] latch_q, latch_d, ladder_latch;
  logic [fps_pkg::CalW-1:0]   calib_cnt_q, calib_cnt_d;
  logic signed [fps_pkg::RawW-1:0] offset_q, offset_d;
  logic                       armed_q, armed_d;
  logic                       pstarted_q, pstarted_d;
  logic [fps_pkg::TimeW-1:0]  pstart_q, pstart_d;
  logic                       lstarted_q, lstarted_d;
  logic [fps_pkg::TimeW-1:0]  lstart_q, lstart_d;

  logic signed [fps_pkg::RawW:0] diff;
  logic [fps_pkg::AltW-1:0]   rel_alt;
  logic [fps_pkg::TimeW-1:0]  pulse_el, land_el;
  logic                       drive, landing;

  // calibration: offset tracks the sample while the count is short
  always_comb begin
    offset_d    = offset_q;
    calib_cnt_d = calib_cnt_q;
    if (calib_cnt_q < cfg_i.calib_samples) begin
      offset_d    = raw_altitude_i;
      calib_cnt_d = calib_cnt_q + 10'd1;
    end
  end

  assign diff = {raw_altitude_i[fps_pkg::RawW-1], raw_altitude_i}
              - {offset_d[fps_pkg::RawW-1], offset_d};

  always_comb begin
    if (diff[fps_pkg::RawW]) begin
      rel_alt = '0;
    end else if (diff[fps_pkg::RawW-1]) begin
      rel_alt = fps_pkg::ALT_MAX;
    end else begin
      rel_alt = diff[fps_pkg::AltW-1:0];
    end
  end

  fps_ladder u_ladder (
    .alt_i   (rel_alt),
    .vel_i   (vertical_velocity_i),
    .phase_i (phase_q),
    .latch_i (latch_q),
    .phase_o (ladder_phase),
    .latch_o (ladder_latch)
  );

  assign phase_d = ladder_phase;
  assign latch_d = separate_cmd_i ? fps_pkg::LATCH_SEP : ladder_latch;

  // separation pulse, one shot until reset
  always_comb begin
    pstarted_d = pstarted_q;
    pstart_d   = pstart_q;
    armed_d    = armed_q;
    drive      = 1'b0;
    if (armed_q && !pstarted_q &&
        (phase_d == fps_pkg::PH_SEPARATE || separate_cmd_i)) begin
      pstarted_d = 1'b1;
      pstart_d   = now_ms_i;
    end
    pulse_el = now_ms_i - pstart_d;
    if (armed_q && pstarted_d) begin
      if (pulse_el > {16'd0, cfg_i.pulse_ms}) begin
        armed_d = 1'b0;
      end else begin
        drive = 1'b1;
      end
    end
  end

  // landing timer starts once
  assign landing = (phase_d == fps_pkg::PH_LANDING);

  always_comb begin
    lstarted_d = lstarted_q;
    lstart_d   = lstart_q;
    if (landing && !lstarted_q) begin
      lstarted_d = 1'b1;
      lstart_d   = now_ms_i;
    end
    land_el = now_ms_i - lstart_d;
  end

  assign result_o.flight_phase      = phase_d;
  assign result_o.relative_altitude = rel_alt;
  assign result_o.separation_drive  = drive;
  assign result_o.buzzer_on         = landing;
  assign result_o.motors_off        = landing && (land_el > {16'd0, cfg_i.motor_off_ms});
  assign result_o.system_off        = landing && (land_el > {14'd0, cfg_i.shutdown_ms});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= fps_pkg::PH_PAD;
      latch_q     <= fps_pkg::LATCH_NONE;
      calib_cnt_q <= '0;
      offset_q    <= '0;
      armed_q     <= 1'b1;
      pstarted_q  <= 1'b0;
      pstart_q    <= '0;
      lstarted_q  <= 1'b0;
      lstart_q    <= '0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      latch_q     <= latch_d;
      calib_cnt_q <= calib_cnt_d;
      offset_q    <= offset_d;
      armed_q     <= armed_d;
      pstarted_q  <= pstarted_d;
      pstart_q    <= pstart_d;
      lstarted_q  <= lstarted_d;
      lstart_q    <= lstart_d;
    end
  end

`ifndef SYNTHESIS
  a_latch_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    latch_q != 2'd3)
    else $error("latch reached unused level");
  a_pulse_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(armed_q) |=> !armed_q)
    else $error("separation pulse re-armed");
  a_drive_needs_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && result_o.separation_drive) |=> pstarted_q)
    else $error("drive without pulse start");
`endif

endmodule

### src/flight_phase_sequencer_unit.sv
// Top level of the flight phase sequencer: stream ports, config and stage registers.
//
// Usage:
//   Sensor samples enter on the s_axis channel, one per beat; each beat yields
//   exactly one result beat on m_axis, in order. Registers are written on the
//   cfg channel (index 0 calib_samples, 1 pulse_ms, 2 motor_off_ms,
//   3 shutdown_ms); cfg_ready_o is always high, write only while idle.
//   An accepted input beat passes through the input register, then the result
//   register, before its result beat is valid. Throughput: one beat per cycle
//   while m_axis_tready_i is high; the phase ladder, calibration subtract and
//   timer compares all fit between the input register and the result register,
//   and the sequencer state updates at the same edge that loads the result.
//   Reset: phase pad, latch clear, calibration restarts, pulse re-armed,
//   landing timer cleared, registers back to their defaults, both stages empty.
//   Stall: when m_axis_tready_i is low and a result is valid, the result register
//   holds; an empty input register still takes one more beat, after which
//   s_axis_tready_o drops until the result is taken.
module flight_phase_sequencer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [19:0] raw_altitude, [35:20] vertical_velocity, [67:36] now_ms,
  // [68] separate_cmd, [71:69] zero
  input  logic [71:0] s_axis_tdata_i,
  // master stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [3:0] flight_phase, [22:4] relative_altitude, [23] separation_drive,
  // [24] buzzer_on, [25] motors_off, [26] system_off, [31:27] zero
  output logic [31:0] m_axis_tdata_o,
  // config write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [fps_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [fps_pkg::CfgDataW-1:0] cfg_data_i
);

  fps_pkg::cfg_t    cfg_q;
  fps_pkg::result_t step_res, res_q;

  logic        in_vld_q, out_vld_q;
  logic [68:0] in_q;
  logic        advance, step;

  // result stage frees when empty or being taken
  assign advance = !out_vld_q || m_axis_tready_i;
  assign step    = in_vld_q && advance;
  assign s_axis_tready_o = !in_vld_q || advance;
  assign cfg_ready_o     = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.calib_samples <= fps_pkg::CALIB_SAMPLES_RST;
      cfg_q.pulse_ms      <= fps_pkg::PULSE_MS_RST;
      cfg_q.motor_off_ms  <= fps_pkg::MOTOR_OFF_MS_RST;
      cfg_q.shutdown_ms   <= fps_pkg::SHUTDOWN_MS_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        fps_pkg::REG_CALIB_SAMPLES: cfg_q.calib_samples <= cfg_data_i[9:0];
        fps_pkg::REG_PULSE_MS:      cfg_q.pulse_ms      <= cfg_data_i[15:0];
        fps_pkg::REG_MOTOR_OFF_MS:  cfg_q.motor_off_ms  <= cfg_data_i[15:0];
        fps_pkg::REG_SHUTDOWN_MS:   cfg_q.shutdown_ms   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_q <= s_axis_tdata_i[68:0];
    end
  end

  fps_state u_state (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .step_i              (step),
    .raw_altitude_i      (in_q[19:0]),
    .vertical_velocity_i (in_q[35:20]),
    .now_ms_i            (in_q[67:36]),
    .separate_cmd_i      (in_q[68]),
    .cfg_i               (cfg_q),
    .result_o            (step_res)
  );

  // result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= step_res;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {5'd0, res_q.system_off, res_q.motors_off, res_q.buzzer_on,
                            res_q.separation_drive, res_q.relative_altitude,
                            res_q.flight_phase};

`ifndef SYNTHESIS
  a_buzz_landing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_q.buzzer_on) |-> (res_q.flight_phase == fps_pkg::PH_LANDING))
    else $error("buzzer outside landing");
  a_off_needs_buzz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (res_q.motors_off || res_q.system_off)) |-> res_q.buzzer_on)
    else $error("shutdown flag outside landing");
  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !advance) |=> in_vld_q)
    else $error("input beat dropped during stall");
`endif

endmodule

### sim/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for flight_phase_sequencer_unit: shadow model, drivers, checks.
module tb;
  import fps_pkg::*;

  // Thresholds of the phase ladder, cm and cm/s
  localparam int A_GROUND  = 500;
  localparam int A_SEP_LO  = 4000;
  localparam int A_DESC1   = 5000;
  localparam int A_APOGEE  = 6000;
  localparam int A_FIX_LO  = 18000;
  localparam int A_FIX_HI  = 22500;
  localparam int A_DESC2   = 39500;
  localparam int A_CEIL    = 524287;
  localparam int V_CLIMB   = 100;
  localparam int V_DRIFT   = -100;
  localparam int V_SINK    = -200;
  localparam int V_FIX_LO  = -300;
  localparam int V_FIX_HI  = 300;

  // Random sample shaping: keep the latch at zero, at one, or let it run free
  localparam int MODE_LATCH0 = 0;
  localparam int MODE_LATCH1 = 1;
  localparam int MODE_FREE   = 2;

  // Cycles without any accepted beat before the run is declared hung
  localparam int STALL_LIMIT = 5000;

  // Shadow copy of the sequencer: config, state and the queue of pending reports
  class phase_shadow;
    logic [9:0]        calib_samples;
    logic [15:0]       pulse_ms;
    logic [15:0]       motor_off_ms;
    logic [17:0]       shutdown_ms;
    logic [PhaseW-1:0] phase;
    logic [LatchW-1:0] latch;
    int unsigned       calib_cnt;
    int                ground_off;
    bit                pulse_armed;
    bit                pulse_started;
    logic [31:0]       pulse_t0;
    bit                land_started;
    logic [31:0]       land_t0;
    result_t           reports_q[$];
    int                mismatches;

    function new();
      calib_samples = CALIB_SAMPLES_RST;
      pulse_ms      = PULSE_MS_RST;
      motor_off_ms  = MOTOR_OFF_MS_RST;
      shutdown_ms   = SHUTDOWN_MS_RST;
      phase         = PH_PAD;
      latch         = LATCH_NONE;
      calib_cnt     = 0;
      ground_off    = 0;
      pulse_armed   = 1'b1;
      pulse_started = 1'b0;
      pulse_t0      = '0;
      land_started  = 1'b0;
      land_t0       = '0;
      mismatches    = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_CALIB_SAMPLES: calib_samples = data[9:0];
        REG_PULSE_MS:      pulse_ms      = data[15:0];
        REG_MOTOR_OFF_MS:  motor_off_ms  = data[15:0];
        REG_SHUTDOWN_MS:   shutdown_ms   = data;
        default: ;
      endcase
    endfunction

    function int clamp_alt(int d);
      if (d < 0) return 0;
      if (d > A_CEIL) return A_CEIL;
      return d;
    endfunction

    // Altitude the next sample would report, used to steer the random stimulus
    function int preview_alt(logic [RawW-1:0] raw_b);
      int raw;
      int g;
      raw = int'($signed(raw_b));
      g = (calib_cnt < calib_samples) ? raw : ground_off;
      return clamp_alt(raw - g);
    endfunction

    function void run_phase_rules(int a, int v);
      if (a < A_GROUND && v >= 0 && v < V_CLIMB && latch == LATCH_NONE) begin
        phase = PH_PAD;
      end else if (a >= A_GROUND && v >= V_CLIMB && latch == LATCH_NONE) begin
        phase = PH_ASCEND;
      end else if (a > A_APOGEE && v < V_CLIMB && v > V_DRIFT && latch == LATCH_NONE) begin
        phase = PH_APOGEE;
      end else if (a > A_DESC1 && v <= V_SINK && latch < LATCH_SEP) begin
        phase = PH_DESC1;
        latch = LATCH_DESC;
      end else if (a < A_DESC1 && a > A_SEP_LO && v < V_SINK && latch <= LATCH_SEP) begin
        phase = PH_SEPARATE;
        latch = LATCH_SEP;
      end else if (a < A_DESC2 && a > A_FIX_HI && v < V_SINK) begin
        phase = PH_DESC2;
        latch = LATCH_SEP;
      end else if (a < A_FIX_HI && a > A_FIX_LO && v > V_FIX_LO && v < V_FIX_HI &&
                   latch == LATCH_SEP) begin
        phase = PH_ALT_FIX;
      end else if (a < A_FIX_LO && v < V_SINK && latch == LATCH_SEP) begin
        phase = PH_DESC3;
      end else if (a < A_GROUND && v < V_CLIMB && v > V_DRIFT && latch == LATCH_SEP) begin
        phase = PH_LANDING;
      end
    endfunction

    // One accepted sample: advance the shadow state and queue the report it causes
    function void note_sample(logic [RawW-1:0] raw_b, logic [VelW-1:0] vel_b,
                              logic [TimeW-1:0] now, logic cmd);
      int          raw;
      int          a;
      int          v;
      logic [31:0] el;
      result_t     r;
      raw = int'($signed(raw_b));
      v   = int'($signed(vel_b));
      if (calib_cnt < calib_samples) begin
        ground_off = raw;
        calib_cnt++;
      end
      a = clamp_alt(raw - ground_off);
      run_phase_rules(a, v);
      if (cmd) latch = LATCH_SEP;

      r = '0;
      // pulse fires once per reset; once started it runs out regardless of request
      if (pulse_armed) begin
        if (!pulse_started && (phase == PH_SEPARATE || cmd)) begin
          pulse_t0      = now;
          pulse_started = 1'b1;
        end
        if (pulse_started) begin
          if (now - pulse_t0 > {16'd0, pulse_ms}) pulse_armed = 1'b0;
          else r.separation_drive = 1'b1;
        end
      end

      // landing timer starts on the first landing step only
      if (phase == PH_LANDING) begin
        r.buzzer_on = 1'b1;
        if (!land_started) begin
          land_t0      = now;
          land_started = 1'b1;
        end
        el = now - land_t0;
        r.motors_off = el > {16'd0, motor_off_ms};
        r.system_off = el > {14'd0, shutdown_ms};
      end

      r.flight_phase      = phase;
      r.relative_altitude = a[AltW-1:0];
      reports_q.push_back(r);
    endfunction

    function void check_report(logic [31:0] beat);
      result_t exp_r;
      if (reports_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected report beat %h", beat);
        return;
      end
      exp_r = reports_q.pop_front();
      if (beat[3:0] !== exp_r.flight_phase || beat[22:4] !== exp_r.relative_altitude ||
          beat[23] !== exp_r.separation_drive || beat[24] !== exp_r.buzzer_on ||
          beat[25] !== exp_r.motors_off || beat[26] !== exp_r.system_off ||
          beat[31:27] !== 5'd0) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"report mismatch: expected phase %0d alt %0d drv %b buz %b mot %b sys %b",
                    " / got phase %0d alt %0d drv %b buz %b mot %b sys %b pad %h"},
                   exp_r.flight_phase, exp_r.relative_altitude, exp_r.separation_drive,
                   exp_r.buzzer_on, exp_r.motors_off, exp_r.system_off,
                   beat[3:0], beat[22:4], beat[23], beat[24], beat[25], beat[26],
                   beat[31:27]);
      end
    endfunction

    function int pending();
      return reports_q.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  // [19:0] raw_altitude, [35:20] vertical_velocity, [67:36] now_ms,
  // [68] separate_cmd, [71:69] zero
  logic [71:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  // [3:0] flight_phase, [22:4] relative_altitude, [23] separation_drive,
  // [24] buzzer_on, [25] motors_off, [26] system_off, [31:27] zero
  logic [31:0] m_axis_tdata_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  phase_shadow shadow;

  // Stimulus bookkeeping
  logic [31:0] clock_ms = '0;
  bit          src_calm = 1'b0;
  bit          sink_calm = 1'b0;
  int          sink_hold = 0;
  int          sink_roll;
  int          idle_cycles = 0;
  int          alt_marks[8] = '{0, 500, 4000, 5000, 6000, 18000, 22500, 39500};
  int          vel_marks[7] = '{-300, -200, -100, 0, 100, 200, 300};

  flight_phase_sequencer_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // Result sink: mostly ready, short stalls, now and then a long one, calm stretches
  always @(negedge clk_i) begin
    if ($urandom_range(0, 299) == 0) sink_calm = !sink_calm;
    if (sink_hold != 0) begin
      m_axis_tready_i <= 1'b0;
      sink_hold = sink_hold - 1;
    end else begin
      m_axis_tready_i <= 1'b1;
      sink_roll = $urandom_range(0, 99);
      if (!sink_calm) begin
        if (sink_roll < 4) sink_hold = $urandom_range(5, 40);
        else if (sink_roll < 25) sink_hold = $urandom_range(1, 3);
      end
    end
  end

  // Beat monitor: every handshake is seen at the rising edge, before the DUT updates.
  // Also the watchdog: a run with no beat moving for too long is hung.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o)
        shadow.note_sample(s_axis_tdata_i[19:0], s_axis_tdata_i[35:20],
                           s_axis_tdata_i[67:36], s_axis_tdata_i[68]);
      if (m_axis_tvalid_o && m_axis_tready_i) shadow.check_report(m_axis_tdata_o);
      if (cfg_valid_i && cfg_ready_o) shadow.write_reg(cfg_index_i, cfg_data_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles = idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

  // Sample beat. Entered and left at a falling edge; tvalid stays high on exit so
  // back-to-back beats need no second assignment in one step.
  task automatic send_sample(input logic [RawW-1:0] raw, input logic [VelW-1:0] vel,
                             input logic [TimeW-1:0] now, input logic cmd);
    int gap;
    int roll;
    if ($urandom_range(0, 149) == 0) src_calm = !src_calm;
    gap  = 0;
    roll = $urandom_range(0, 99);
    if (!src_calm) begin
      if (roll >= 90) gap = $urandom_range(4, 40);
      else if (roll >= 55) gap = $urandom_range(1, 3);
    end
    if (gap != 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = {3'b000, cmd, now, vel, raw};
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
  endtask

  // Directed sample given as altitude above the current ground offset
  task automatic send_alt(input int a, input int v, input logic [31:0] now, input logic cmd);
    send_sample(20'(shadow.ground_off + a), 16'(v), now, cmd);
  endtask

  // Wait until every queued report has come back; the sequencer is then idle
  task automatic drain();
    s_axis_tvalid_i = 1'b0;
    while (shadow.pending() != 0) @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // True when a sample would lift the latch beyond what the current mode allows
  function automatic bit raises_latch(int mode, int a, int v);
    bit sep;
    bit desc2;
    bit desc1;
    sep   = a > A_SEP_LO && a < A_DESC1 && v < V_SINK;
    desc2 = a > A_FIX_HI && a < A_DESC2 && v < V_SINK;
    desc1 = a > A_DESC1 && v <= V_SINK;
    return sep || desc2 || (mode == MODE_LATCH0 && desc1);
  endfunction

  // Random flight samples: altitudes and speeds clustered on the ladder thresholds,
  // some uniform, some clamped or saturated, a tenth pure noise.
  task automatic run_random(input int mode, input int count);
    int              k;
    int              a;
    int              v;
    logic [RawW-1:0] raw;
    logic [VelW-1:0] vel;
    logic [31:0]     now;
    logic            cmd;
    for (k = 0; k < count; k++) begin
      do begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: a = alt_marks[$urandom_range(0, 7)] + int'($urandom_range(0, 4)) - 2;
          4, 5, 6, 7: a = int'($urandom_range(0, 45000));
          8:          a = int'($urandom_range(45000, 600000));
          default:    a = -int'($urandom_range(1, 3000));
        endcase
        if ($urandom_range(0, 9) == 0) raw = 20'($urandom);
        else raw = 20'(shadow.ground_off + a);
        case ($urandom_range(0, 9))
          0, 1, 2, 3: vel = 16'(vel_marks[$urandom_range(0, 6)] +
                                int'($urandom_range(0, 4)) - 2);
          4, 5, 6, 7: vel = 16'(int'($urandom_range(0, 2000)) - 1000);
          default:    vel = 16'($urandom);
        endcase
        v = int'($signed(vel));
      end while (mode != MODE_FREE && raises_latch(mode, shadow.preview_alt(raw), v));

      if ($urandom_range(0, 19) == 0) clock_ms = $urandom;
      else clock_ms = clock_ms + $urandom_range(0, 60);
      now = clock_ms;
      // after touchdown, aim many timestamps at the shutdown timers
      if (mode == MODE_FREE && shadow.land_started && $urandom_range(0, 1) == 1)
        now = shadow.land_t0 + $urandom_range(0, 300000);
      cmd = (mode == MODE_FREE) && ($urandom_range(0, 7) == 0);
      send_sample(raw, vel, now, cmd);
    end
  endtask

  initial begin : stimulus
    logic [31:0] t0;
    logic [31:0] t1;
    shadow = new();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset config: calibration running, so every report sits at zero altitude.
    // Field extremes go through here without disturbing the latch.
    send_sample(20'h80000, 16'h8000, 32'h0000_0000, 1'b0);
    send_sample(20'h7FFFF, 16'h7FFF, 32'hFFFF_FFFF, 1'b0);
    send_sample(20'h00000, 16'd0,    32'h0000_0001, 1'b0);
    send_sample(20'h7FFFF, 16'd99,   32'h0000_0002, 1'b0);
    send_sample(20'h80000, 16'd100,  32'h0000_0003, 1'b0);
    send_sample(20'hFFFFF, 16'hFFFF, 32'h8000_0000, 1'b0);
    send_sample(20'h55555, 16'hAAAA, 32'h5555_5555, 1'b0);
    send_sample(20'd1500,  16'd50,   32'h0000_0010, 1'b0);

    // Calibration disabled while the count is already past it; short timers
    drain();
    write_cfg(REG_CALIB_SAMPLES, 18'd0);
    write_cfg(REG_PULSE_MS,      18'd40);
    write_cfg(REG_MOTOR_OFF_MS,  18'd100);
    write_cfg(REG_SHUTDOWN_MS,   18'd300);
    clock_ms = 32'd1000;
    run_random(MODE_LATCH0, 300);

    // Raising the sample count resumes calibration for the remaining samples
    drain();
    write_cfg(REG_CALIB_SAMPLES, 18'd20);
    run_random(MODE_LATCH0, 250);

    // First descend at its boundary speed moves the latch to one
    send_alt(6000, -200, clock_ms, 1'b0);
    run_random(MODE_LATCH1, 250);

    // Separation pulse: started either by the ground command outside the
    // separation phase or by the separation phase itself, across the 2^32 wrap.
    t0 = 32'hFFFF_FFF0;
    if ($urandom_range(0, 1) == 1) send_alt(1000, 0, t0, 1'b1);
    else send_alt(4500, -201, t0, 1'b0);
    send_alt(30000, -250, t0 + 32'd20, 1'b0);  // request gone, pulse keeps running
    send_alt(30000, -250, t0 + 32'd40, 1'b0);  // last millisecond of the pulse
    send_alt(30000, -250, t0 + 32'd41, 1'b0);  // expiry releases the drive
    send_alt(4500, -250, t0 + 32'd1, 1'b1);    // no second pulse until reset

    // Descent to touchdown, then the landing timers
    t1 = 32'h0002_0000;
    send_alt(20000, 0, t1, 1'b0);
    send_alt(10000, -250, t1, 1'b0);
    send_alt(0, 0, t1, 1'b0);
    send_alt(0, 0, t1 + 32'd100, 1'b0);
    send_alt(0, 0, t1 + 32'd101, 1'b0);
    send_alt(0, 0, t1 + 32'd300, 1'b0);
    send_alt(0, 0, t1 + 32'd301, 1'b0);
    send_alt(30000, -250, t1 + 32'd302, 1'b0);  // leaving landing clears the flags
    send_alt(499, -99, t1 + 32'd5, 1'b0);       // back in landing, timer not restarted
    clock_ms = t1;

    // Latch at two from here on; sweep the timer registers through their extremes
    drain();
    write_cfg(REG_MOTOR_OFF_MS, 18'd0);
    write_cfg(REG_SHUTDOWN_MS,  18'd0);
    write_cfg(REG_PULSE_MS,     18'd0);
    run_random(MODE_FREE, 200);

    drain();
    write_cfg(REG_MOTOR_OFF_MS, 18'd65535);
    write_cfg(REG_SHUTDOWN_MS,  18'd262143);
    write_cfg(REG_PULSE_MS,     18'd65535);
    run_random(MODE_FREE, 200);

    drain();
    write_cfg(REG_MOTOR_OFF_MS, 18'($urandom_range(0, 65535)));
    write_cfg(REG_SHUTDOWN_MS,  18'($urandom_range(0, 262143)));
    run_random(MODE_FREE, 200);

    // Largest sample count: calibration runs again and pins the altitude at zero
    drain();
    write_cfg(REG_CALIB_SAMPLES, 18'd1023);
    run_random(MODE_FREE, 150);

    drain();
    repeat (8) @(posedge clk_i);
    if (shadow.mismatches == 0 && shadow.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
